FILE: hw/rtl/duplex_motor_frame_bridge_defines.svh
// Assertion macros for the duplex motor frame bridge.
// Each macro expects clk and arst_n in scope.
`ifndef DUPLEX_MOTOR_FRAME_BRIDGE_DEFINES_SVH
`define DUPLEX_MOTOR_FRAME_BRIDGE_DEFINES_SVH

`ifndef SYNTHESIS

`define DMFB_ASSERT_HOLD(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`define DMFB_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define DMFB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DMFB_ASSERT_HOLD(label, cond, msg)

`define DMFB_ASSERT_IMPL(label, ante, cons, msg)

`define DMFB_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/dmfb_pkg.sv
package dmfb_pkg;

	typedef logic [7:0] byte_t;

	localparam int FRAME_BYTES = 24;
	localparam logic [4:0] LAST_BYTE = 5'd23;
	localparam logic [4:0] FIRST_WORD_BYTE = 5'd2;
	localparam logic [4:0] FLAGS_BYTE = 5'd22;
	localparam int NUM_RX_WORDS = 5;
	localparam int NUM_FB_WORDS = 3;

	localparam logic OP_FEEDBACK = 1'b0;
	localparam logic OP_BYTE = 1'b1;

	localparam logic CFG_FEEDBACK_HEADER = 1'b0;
	localparam logic CFG_COMMAND_HEADER = 1'b1;

	localparam byte_t FEEDBACK_HEADER_RESET = 8'd165;
	localparam byte_t COMMAND_HEADER_RESET = 8'd90;

	localparam byte_t VALID_FLAG_SET = 8'h01;
	localparam byte_t VALID_FLAG_CLEAR = 8'h00;

endpackage

FILE: hw/rtl/duplex_motor_frame_bridge.sv
// Full-duplex 24-byte frame bridge. Each accepted transaction is either a feedback update
// (op 0) or one frame byte exchange (op 1), and each yields exactly one result transaction.
// The block takes one transaction per clock cycle while in_stall is low; its result appears
// in the output register in the cycle after acceptance, and in_stall rises only while that
// register holds a result that out_stall is holding back. On frame byte 0 the outgoing frame
// (header, motor id, position, velocity, torque, eight zero bytes, valid flag, XOR checksum)
// is captured from the stored feedback; on the last byte the received references, flags and
// frame status are reported. Configuration writes take effect at the next transaction.
`include "duplex_motor_frame_bridge_defines.svh"

module duplex_motor_frame_bridge
	import dmfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  motor_id,
	input  logic [31:0] position_bits,
	input  logic [31:0] velocity_bits,
	input  logic [31:0] torque_bits,
	input  logic        is_parameter_reply,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tx_byte,
	output logic        frame_end,
	output logic        frame_good,
	output logic        send_enable,
	output logic [31:0] position_ref,
	output logic [31:0] velocity_ref,
	output logic [31:0] stiffness_gain,
	output logic [31:0] damping_gain,
	output logic [31:0] feedforward_torque,
	output logic [7:0]  command_flags
);

	byte_t fb_header_q;
	byte_t cmd_header_q;

	logic [4:0] byte_pos_q;
	byte_t rx_parity_q;
	logic header_matched_q;
	logic [NUM_RX_WORDS-1:0][3:0][7:0] rx_words_q;
	byte_t rx_flags_q;
	logic [NUM_FB_WORDS-1:0][31:0] fb_words_q;
	byte_t fb_motor_q;
	logic valid_seen_q;
	logic [FRAME_BYTES-1:0][7:0] snap_q;

	logic out_valid_q;
	byte_t tx_byte_q;
	logic frame_end_q;
	logic frame_good_q;
	logic send_enable_q;
	logic [NUM_RX_WORDS-1:0][31:0] ref_words_q;
	byte_t flags_out_q;

	logic in_accept;
	logic byte_accept;
	logic [4:0] pos;
	logic first_byte;
	logic last_byte;
	logic [4:0] word_off;
	logic [FRAME_BYTES-1:0][7:0] frame_now;
	byte_t tx_parity;
	byte_t tx_now;
	byte_t rx_parity_now;
	logic header_now;
	logic good_now;

	assign in_stall = out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;
	assign byte_accept = in_accept & (op == OP_BYTE);

	assign pos = (byte_pos_q > LAST_BYTE) ? LAST_BYTE : byte_pos_q;
	assign first_byte = (pos == 5'd0);
	assign last_byte = (pos == LAST_BYTE);
	assign word_off = pos - FIRST_WORD_BYTE;

	always_comb begin
		frame_now = '0;
		frame_now[0] = fb_header_q;
		frame_now[1] = fb_motor_q;
		for (int w = 0; w < NUM_FB_WORDS; w++) begin
			for (int b = 0; b < 4; b++) begin
				frame_now[2 + 4 * w + b] = fb_words_q[w][8 * b +: 8];
			end
		end
		frame_now[FLAGS_BYTE] = valid_seen_q ? VALID_FLAG_SET : VALID_FLAG_CLEAR;
		tx_parity = '0;
		for (int i = 0; i < FRAME_BYTES - 1; i++) begin
			tx_parity = tx_parity ^ frame_now[i];
		end
		frame_now[LAST_BYTE] = tx_parity;
	end

	assign tx_now = first_byte ? fb_header_q : snap_q[pos];
	assign rx_parity_now = first_byte ? 8'd0 : rx_parity_q;
	assign header_now = first_byte ? (rx_byte == cmd_header_q) : header_matched_q;
	assign good_now = header_now & (rx_byte == rx_parity_now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_header_q <= FEEDBACK_HEADER_RESET;
			cmd_header_q <= COMMAND_HEADER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FEEDBACK_HEADER: fb_header_q <= cfg_data;
				CFG_COMMAND_HEADER:  cmd_header_q <= cfg_data;
				default:             fb_header_q <= fb_header_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			rx_parity_q <= '0;
			header_matched_q <= 1'b0;
			rx_words_q <= '0;
			rx_flags_q <= '0;
			fb_words_q <= '0;
			fb_motor_q <= '0;
			valid_seen_q <= 1'b0;
		end else if (in_accept) begin
			if (op == OP_FEEDBACK) begin
				fb_motor_q <= motor_id;
				fb_words_q[0] <= position_bits;
				fb_words_q[1] <= velocity_bits;
				fb_words_q[2] <= torque_bits;
				if (!is_parameter_reply) begin
					valid_seen_q <= 1'b1;
				end
			end else if (last_byte) begin
				byte_pos_q <= '0;
			end else begin
				rx_parity_q <= rx_parity_now ^ rx_byte;
				header_matched_q <= header_now;
				if (pos >= FIRST_WORD_BYTE && pos < FLAGS_BYTE) begin
					rx_words_q[word_off[4:2]][word_off[1:0]] <= rx_byte;
				end else if (pos == FLAGS_BYTE) begin
					rx_flags_q <= rx_byte;
				end
				byte_pos_q <= pos + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_accept && first_byte) begin
			snap_q <= frame_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			tx_byte_q <= '0;
			frame_end_q <= 1'b0;
			frame_good_q <= 1'b0;
			send_enable_q <= 1'b0;
			ref_words_q <= '0;
			flags_out_q <= '0;
			if (op == OP_BYTE) begin
				tx_byte_q <= tx_now;
				if (last_byte) begin
					frame_end_q <= 1'b1;
					frame_good_q <= good_now;
					send_enable_q <= good_now & rx_flags_q[0];
					ref_words_q <= rx_words_q;
					flags_out_q <= rx_flags_q;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign tx_byte = tx_byte_q;
	assign frame_end = frame_end_q;
	assign frame_good = frame_good_q;
	assign send_enable = send_enable_q;
	assign position_ref = ref_words_q[0];
	assign velocity_ref = ref_words_q[1];
	assign stiffness_gain = ref_words_q[2];
	assign damping_gain = ref_words_q[3];
	assign feedforward_torque = ref_words_q[4];
	assign command_flags = flags_out_q;

	`DMFB_ASSERT_HOLD(a_pos_in_frame, byte_pos_q <= LAST_BYTE, "byte position past frame end")
	`DMFB_ASSERT_NEXT(a_wrap_at_end, byte_accept && last_byte, byte_pos_q == 5'd0, "frame did not restart")
	`DMFB_ASSERT_IMPL(a_good_at_end, out_valid && frame_good, frame_end, "frame_good outside frame end")
	`DMFB_ASSERT_IMPL(a_send_needs_good, out_valid && send_enable, frame_good && command_flags[0], "send_enable without good frame")
	`DMFB_ASSERT_NEXT(a_result_follows, in_accept, out_valid, "accepted transaction gave no result")

endmodule
